/* design/apcq_pkg.sv */
// Shared types, constants and the task-file table of the ATA PIO command queue.
package apcq_pkg;

  localparam int unsigned QUEUE_DEPTH    = 16;
  localparam int unsigned PTR_W          = $clog2(QUEUE_DEPTH);
  localparam int unsigned COUNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMD_FIFO_DEPTH = 2;
  localparam int unsigned TF_WRITES      = 6;
  localparam int unsigned STEP_W         = $clog2(TF_WRITES);

  localparam int unsigned LBA_W  = 28;
  localparam int unsigned ADDR_W = 32;

  localparam logic [1:0] REQ_READ     = 2'd0;
  localparam logic [1:0] REQ_IDENTIFY = 2'd1;
  localparam logic [1:0] REQ_IRQ      = 2'd2;

  localparam logic [2:0] KIND_REG_WRITE = 3'd0;
  localparam logic [2:0] KIND_XFER      = 3'd1;
  localparam logic [2:0] KIND_ACCEPTED  = 3'd2;
  localparam logic [2:0] KIND_QUEUE_FULL = 3'd3;
  localparam logic [2:0] KIND_DRIVE_ERR = 3'd4;
  localparam logic [2:0] KIND_NOT_ATA   = 3'd5;
  localparam logic [2:0] KIND_NO_DRIVE  = 3'd6;

  localparam logic [2:0] TF_SECCOUNT = 3'd2;
  localparam logic [2:0] TF_LBA_LO   = 3'd3;
  localparam logic [2:0] TF_LBA_MID  = 3'd4;
  localparam logic [2:0] TF_LBA_HI   = 3'd5;
  localparam logic [2:0] TF_DRIVE    = 3'd6;
  localparam logic [2:0] TF_COMMAND  = 3'd7;

  localparam logic [7:0] DRV_LBA_MASTER = 8'hE0;
  localparam logic [7:0] DRV_IDENTIFY   = 8'hA0;
  localparam logic [7:0] CMD_READ_SECT  = 8'h20;
  localparam logic [7:0] CMD_IDENTIFY   = 8'hEC;

  localparam int unsigned STATUS_ERR_BIT = 0;
  localparam int unsigned STATUS_DRQ_BIT = 3;

  typedef enum logic [1:0] {
    OP_READ,
    OP_IDENT,
    OP_IRQ,
    OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REPORT,
    ST_LOAD,
    ST_ISSUE,
    ST_ACCEPT
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [LBA_W-1:0]  lba;
    logic [ADDR_W-1:0] addr;
    logic              err;
    logic              drq;
    logic              status_zero;
    logic              sig_nonzero;
  } cmd_t;

  typedef struct packed {
    logic              ident;
    logic [LBA_W-1:0]  lba;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  typedef struct packed {
    logic [2:0] offset;
    logic [7:0] data;
  } tf_write_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [2:0]        reg_offset;
    logic [7:0]        reg_data;
    logic [ADDR_W-1:0] xfer_addr;
    logic              last;
  } result_t;

  function automatic tf_write_t tf_write(input logic [STEP_W-1:0] step, input logic ident,
                                         input logic [LBA_W-1:0] lba);
    tf_write_t w;
    w = '0;
    case (step)
      STEP_W'(0): begin
        w.offset = TF_DRIVE;
        w.data   = ident ? DRV_IDENTIFY : (DRV_LBA_MASTER | {4'h0, lba[27:24]});
      end
      STEP_W'(1): begin
        w.offset = TF_SECCOUNT;
        w.data   = ident ? 8'h00 : 8'h01;
      end
      STEP_W'(2): begin
        w.offset = TF_LBA_LO;
        w.data   = ident ? 8'h00 : lba[7:0];
      end
      STEP_W'(3): begin
        w.offset = TF_LBA_MID;
        w.data   = ident ? 8'h00 : lba[15:8];
      end
      STEP_W'(4): begin
        w.offset = TF_LBA_HI;
        w.data   = ident ? 8'h00 : lba[23:16];
      end
      default: begin
        w.offset = TF_COMMAND;
        w.data   = ident ? CMD_IDENTIFY : CMD_READ_SECT;
      end
    endcase
    return w;
  endfunction

endpackage

/* design/apcq_ifs.sv */
// Request and result channel interfaces of the ATA PIO command queue.
interface apcq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [27:0] lba;
  logic [31:0] buffer_addr;
  logic [7:0]  status_byte;
  logic        signature_nonzero;

  modport source (output valid, req_type, lba, buffer_addr, status_byte, signature_nonzero,
                  input ready);
  modport sink (input valid, req_type, lba, buffer_addr, status_byte, signature_nonzero,
                output ready);
endinterface

interface apcq_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  reg_offset;
  logic [7:0]  reg_data;
  logic [31:0] xfer_addr;
  logic        last;

  modport source (output valid, kind, reg_offset, reg_data, xfer_addr, last, input ready);
  modport sink (input valid, kind, reg_offset, reg_data, xfer_addr, last, output ready);
endinterface

/* design/apcq_cmd_fifo.sv */
// Short command queue that decouples the request decoder from the command sequencer.
module apcq_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  apcq_pkg::cmd_t  wdata_i,
  output logic            ready_o,
  input  logic            pop_i,
  output apcq_pkg::cmd_t  rdata_o,
  output logic            valid_o
);

  localparam int unsigned FPTR_W = $clog2(apcq_pkg::CMD_FIFO_DEPTH);
  localparam int unsigned FCNT_W = $clog2(apcq_pkg::CMD_FIFO_DEPTH + 1);

  apcq_pkg::cmd_t    slot_q [apcq_pkg::CMD_FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign ready_o = (cnt_q != FCNT_W'(apcq_pkg::CMD_FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = slot_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FPTR_W'(apcq_pkg::CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FPTR_W'(apcq_pkg::CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* design/apcq_front.sv */
// Request decoder that accepts transfers and classifies them into commands.
module apcq_front (
  apcq_req_if.sink         req_i,
  input  logic             fifo_ready_i,
  output logic             push_o,
  output apcq_pkg::cmd_t   cmd_o
);

  apcq_pkg::op_e op;

  always_comb begin
    case (req_i.req_type)
      apcq_pkg::REQ_READ:     op = apcq_pkg::OP_READ;
      apcq_pkg::REQ_IDENTIFY: op = apcq_pkg::OP_IDENT;
      apcq_pkg::REQ_IRQ:      op = apcq_pkg::OP_IRQ;
      default:                op = apcq_pkg::OP_NONE;
    endcase
  end

  assign req_i.ready = fifo_ready_i;
  assign push_o      = req_i.valid && fifo_ready_i && (op != apcq_pkg::OP_NONE);

  always_comb begin
    cmd_o             = '0;
    cmd_o.op          = op;
    cmd_o.lba         = (op == apcq_pkg::OP_IDENT) ? '0 : req_i.lba;
    cmd_o.addr        = req_i.buffer_addr;
    cmd_o.err         = req_i.status_byte[apcq_pkg::STATUS_ERR_BIT];
    cmd_o.drq         = req_i.status_byte[apcq_pkg::STATUS_DRQ_BIT];
    cmd_o.status_zero = (req_i.status_byte == 8'h00);
    cmd_o.sig_nonzero = req_i.signature_nonzero;
  end

endmodule

/* design/apcq_back.sv */
// Command sequencer that tracks the command in flight, queues pending ones and emits results.
module apcq_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  apcq_pkg::cmd_t  cmd_i,
  output logic            pop_o,
  apcq_res_if.source      res_o
);

  localparam int unsigned PTR_W   = apcq_pkg::PTR_W;
  localparam int unsigned COUNT_W = apcq_pkg::COUNT_W;
  localparam int unsigned STEP_W  = apcq_pkg::STEP_W;

  apcq_pkg::state_e  state_q, state_d;
  logic              busy_q, busy_d;
  logic              act_ident_q, act_ident_d;
  logic [27:0]       act_lba_q, act_lba_d;
  logic [31:0]       act_addr_q, act_addr_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              acc_after_q, acc_after_d;
  logic              dispatch_q, dispatch_d;
  logic [2:0]        rep_kind_q, rep_kind_d;
  logic [31:0]       rep_addr_q, rep_addr_d;
  logic              rep_last_q, rep_last_d;
  logic              res_valid_q, res_valid_d;
  apcq_pkg::result_t res_q, res_d;

  apcq_pkg::entry_t  mem_q [apcq_pkg::QUEUE_DEPTH];
  apcq_pkg::entry_t  rd_data_q;
  apcq_pkg::entry_t  wr_entry;
  logic              mem_we;
  logic              mem_re;

  logic              can_emit;
  logic              is_sub;
  logic              is_irq;
  logic              full;
  logic              has_pending;
  logic              sub_issue, sub_full, sub_queue;
  logic              irq_err, irq_done, irq_report;
  logic [2:0]        irq_kind;
  logic              last_step;
  apcq_pkg::tf_write_t tf;

  assign can_emit    = !res_valid_q || res_o.ready;
  assign pop_o       = (state_q == apcq_pkg::ST_IDLE) && cmd_valid_i;
  assign is_sub      = (cmd_i.op == apcq_pkg::OP_READ) || (cmd_i.op == apcq_pkg::OP_IDENT);
  assign is_irq      = (cmd_i.op == apcq_pkg::OP_IRQ);
  assign full        = (count_q == COUNT_W'(apcq_pkg::QUEUE_DEPTH));
  assign has_pending = (count_q != '0);
  assign sub_issue   = pop_o && is_sub && !busy_q;
  assign sub_full    = pop_o && is_sub && busy_q && full;
  assign sub_queue   = pop_o && is_sub && busy_q && !full;
  assign irq_err     = pop_o && is_irq && busy_q && cmd_i.err;
  assign irq_done    = pop_o && is_irq && busy_q && !cmd_i.err;
  assign last_step   = (step_q == STEP_W'(apcq_pkg::TF_WRITES - 1));
  assign tf          = apcq_pkg::tf_write(step_q, act_ident_q, act_lba_q);

  always_comb begin
    irq_report = 1'b1;
    irq_kind   = apcq_pkg::KIND_XFER;
    if (act_ident_q && cmd_i.status_zero) begin
      irq_kind = apcq_pkg::KIND_NO_DRIVE;
    end else if (act_ident_q && cmd_i.sig_nonzero) begin
      irq_kind = apcq_pkg::KIND_NOT_ATA;
    end else if (!cmd_i.drq) begin
      irq_report = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      apcq_pkg::ST_IDLE: begin
        if (sub_issue) begin
          state_d = apcq_pkg::ST_ISSUE;
        end else if (sub_full || sub_queue || irq_err || (irq_done && irq_report)) begin
          state_d = apcq_pkg::ST_REPORT;
        end else if (irq_done && has_pending) begin
          state_d = apcq_pkg::ST_LOAD;
        end
      end
      apcq_pkg::ST_REPORT: begin
        if (can_emit) begin
          state_d = dispatch_q ? apcq_pkg::ST_LOAD : apcq_pkg::ST_IDLE;
        end
      end
      apcq_pkg::ST_LOAD: begin
        state_d = apcq_pkg::ST_ISSUE;
      end
      apcq_pkg::ST_ISSUE: begin
        if (can_emit && last_step) begin
          state_d = acc_after_q ? apcq_pkg::ST_ACCEPT : apcq_pkg::ST_IDLE;
        end
      end
      apcq_pkg::ST_ACCEPT: begin
        if (can_emit) begin
          state_d = apcq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = apcq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    act_ident_d = act_ident_q;
    act_lba_d   = act_lba_q;
    act_addr_d  = act_addr_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    step_d      = step_q;
    acc_after_d = acc_after_q;
    dispatch_d  = dispatch_q;
    rep_kind_d  = rep_kind_q;
    rep_addr_d  = rep_addr_q;
    rep_last_d  = rep_last_q;
    res_valid_d = res_valid_q && !res_o.ready;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    wr_entry.ident = (cmd_i.op == apcq_pkg::OP_IDENT);
    wr_entry.lba   = cmd_i.lba;
    wr_entry.addr  = cmd_i.addr;

    case (state_q)
      apcq_pkg::ST_IDLE: begin
        if (sub_issue) begin
          busy_d      = 1'b1;
          act_ident_d = (cmd_i.op == apcq_pkg::OP_IDENT);
          act_lba_d   = cmd_i.lba;
          act_addr_d  = cmd_i.addr;
          step_d      = '0;
          acc_after_d = 1'b1;
        end
        if (sub_full) begin
          rep_kind_d = apcq_pkg::KIND_QUEUE_FULL;
          rep_addr_d = '0;
          rep_last_d = 1'b1;
          dispatch_d = 1'b0;
        end
        if (sub_queue) begin
          mem_we     = 1'b1;
          tail_d     = (tail_q == PTR_W'(apcq_pkg::QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
          count_d    = count_q + 1'b1;
          rep_kind_d = apcq_pkg::KIND_ACCEPTED;
          rep_addr_d = '0;
          rep_last_d = 1'b1;
          dispatch_d = 1'b0;
        end
        if (irq_err) begin
          rep_kind_d = apcq_pkg::KIND_DRIVE_ERR;
          rep_addr_d = '0;
          rep_last_d = 1'b1;
          dispatch_d = 1'b0;
        end
        if (irq_done) begin
          busy_d      = 1'b0;
          act_ident_d = 1'b0;
          act_addr_d  = '0;
          dispatch_d  = has_pending;
          rep_kind_d  = irq_kind;
          rep_addr_d  = (irq_kind == apcq_pkg::KIND_XFER) ? act_addr_q : '0;
          rep_last_d  = !has_pending;
          if (has_pending) begin
            mem_re  = 1'b1;
            head_d  = (head_q == PTR_W'(apcq_pkg::QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
            count_d = count_q - 1'b1;
          end
        end
      end
      apcq_pkg::ST_REPORT: begin
        if (can_emit) begin
          res_valid_d      = 1'b1;
          res_d.kind       = rep_kind_q;
          res_d.reg_offset = '0;
          res_d.reg_data   = '0;
          res_d.xfer_addr  = rep_addr_q;
          res_d.last       = rep_last_q;
        end
      end
      apcq_pkg::ST_LOAD: begin
        busy_d      = 1'b1;
        act_ident_d = rd_data_q.ident;
        act_lba_d   = rd_data_q.lba;
        act_addr_d  = rd_data_q.addr;
        step_d      = '0;
        acc_after_d = 1'b0;
      end
      apcq_pkg::ST_ISSUE: begin
        if (can_emit) begin
          res_valid_d      = 1'b1;
          res_d.kind       = apcq_pkg::KIND_REG_WRITE;
          res_d.reg_offset = tf.offset;
          res_d.reg_data   = tf.data;
          res_d.xfer_addr  = '0;
          res_d.last       = last_step && !acc_after_q;
          step_d           = step_q + 1'b1;
        end
      end
      apcq_pkg::ST_ACCEPT: begin
        if (can_emit) begin
          res_valid_d      = 1'b1;
          res_d.kind       = apcq_pkg::KIND_ACCEPTED;
          res_d.reg_offset = '0;
          res_d.reg_data   = '0;
          res_d.xfer_addr  = '0;
          res_d.last       = 1'b1;
        end
      end
      default: begin
        res_valid_d = res_valid_q && !res_o.ready;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apcq_pkg::ST_IDLE;
      busy_q      <= 1'b0;
      act_ident_q <= 1'b0;
      act_lba_q   <= '0;
      act_addr_q  <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      step_q      <= '0;
      acc_after_q <= 1'b0;
      dispatch_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      act_ident_q <= act_ident_d;
      act_lba_q   <= act_lba_d;
      act_addr_q  <= act_addr_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      step_q      <= step_d;
      acc_after_q <= acc_after_d;
      dispatch_q  <= dispatch_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rep_kind_q <= rep_kind_d;
    rep_addr_q <= rep_addr_d;
    rep_last_q <= rep_last_d;
    res_q      <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= wr_entry;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[head_q];
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.kind       = res_q.kind;
  assign res_o.reg_offset = res_q.reg_offset;
  assign res_o.reg_data   = res_q.reg_data;
  assign res_o.xfer_addr  = res_q.xfer_addr;
  assign res_o.last       = res_q.last;

endmodule

/* design/ata_pio_command_queue_core.sv */
// Top level of the ATA PIO command queue: decoder, command queue and sequencer.
//
//   Port    Direction  Transfer carries
//   req_i   sink       req_type, lba, buffer_addr, status_byte, signature_nonzero
//   res_o   source     kind, reg_offset, reg_data, xfer_addr, last
//
// A request passes through the registered command queue before it reaches the
// sequencer; results leave at one per cycle from a registered output stage while the
// result port is ready, and an issue is a serial sequence of task-file register writes.
// Dispatching a queued command goes through a registered read of the pending
// memory. Reset is asynchronous and clears all control state; the pending memory is
// not cleared. A stalled result holds the sequencer while the decoder keeps filling
// the two-entry command queue.
module ata_pio_command_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  apcq_req_if.sink    req_i,
  apcq_res_if.source  res_o
);

  logic           fifo_ready;
  logic           push;
  logic           pop;
  logic           cmd_valid;
  apcq_pkg::cmd_t cmd_in;
  apcq_pkg::cmd_t cmd_out;

  apcq_front u_front (
    .req_i        (req_i),
    .fifo_ready_i (fifo_ready),
    .push_o       (push),
    .cmd_o        (cmd_in)
  );

  apcq_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .ready_o (fifo_ready),
    .pop_i   (pop),
    .rdata_o (cmd_out),
    .valid_o (cmd_valid)
  );

  apcq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule

/* design/apcq_checker.sv */
// Port-level checker for the ATA PIO command queue and its bind to the top level.
module apcq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [2:0]  res_kind_i,
  input logic [2:0]  res_reg_offset_i,
  input logic [7:0]  res_reg_data_i,
  input logic [31:0] res_xfer_addr_i,
  input logic        res_last_i
);

  logic res_xfer;

  assign res_xfer = res_valid_i && res_ready_i;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_kind_i)
      && $stable(res_reg_offset_i) && $stable(res_reg_data_i)
      && $stable(res_xfer_addr_i) && $stable(res_last_i))
    else $error("Stalled result changed.");

  a_cmd_write_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_xfer && (res_kind_i == apcq_pkg::KIND_REG_WRITE)
      && (res_reg_offset_i != apcq_pkg::TF_COMMAND) |-> !res_last_i)
    else $error("A task-file write other than the command write ended a sequence.");

  a_report_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_xfer && (res_kind_i != apcq_pkg::KIND_REG_WRITE) |->
      (res_reg_offset_i == 3'd0) && (res_reg_data_i == 8'd0)
      && ((res_kind_i == apcq_pkg::KIND_XFER) || (res_xfer_addr_i == 32'd0)))
    else $error("A report carries stray register or address fields.");

  a_final_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_xfer && ((res_kind_i == apcq_pkg::KIND_ACCEPTED)
      || (res_kind_i == apcq_pkg::KIND_QUEUE_FULL)
      || (res_kind_i == apcq_pkg::KIND_DRIVE_ERR)) |-> res_last_i)
    else $error("A submission or error report was not the final result.");

endmodule

bind ata_pio_command_queue_core apcq_checker u_apcq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_kind_i       (res_o.kind),
  .res_reg_offset_i (res_o.reg_offset),
  .res_reg_data_i   (res_o.reg_data),
  .res_xfer_addr_i  (res_o.xfer_addr),
  .res_last_i       (res_o.last)
);
